/* src/fas_pkg.sv */
package fas_pkg;

  // field widths
  localparam int DUR_W      = 20;
  localparam int SPD_W      = 16;
  localparam int FC_W       = 7;
  localparam int REP_W      = 8;
  localparam int POS_W      = 7;
  localparam int DISP_W     = 6;
  localparam int ELAP_W     = 32;
  localparam int DELTA_W    = 16;
  localparam int FUNC_W     = 2;
  localparam int PROD_W     = SPD_W + FC_W;
  localparam int DEN_W      = DUR_W + 8;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int PC_W       = 4;

  // largest number of frames in use
  localparam int MAX_FRAMES = 64;

  // divider pass lengths, one quotient bit per cycle
  localparam logic [CNT_W-1:0] DIV_FT_STEPS  = CNT_W'(DEN_W);
  localparam logic [CNT_W-1:0] DIV_MOD_STEPS = CNT_W'(ELAP_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP     = 3'd4;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;

  typedef enum logic [1:0] {
    MODE_INITIAL   = 2'd0,
    MODE_PLAYING   = 2'd1,
    MODE_COMPLETED = 2'd2,
    MODE_STOPPED   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [DELTA_W-1:0] delta_ms;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        play_state;
    logic [DISP_W-1:0] shown_frame;
    logic              frame_changed;
    logic              began_playing;
    logic              finished;
    logic              control_notice;
  } out_beat_t;

  // configuration as the datapath uses it, with range fixes applied
  typedef struct packed {
    logic [DUR_W-1:0] duration_ms;
    logic [SPD_W-1:0] speed_eff;
    logic [FC_W-1:0]  frames_eff;
    logic [REP_W-1:0] repeat_count;
    logic             loop_enable;
  } cfg_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_ACCEPT,
    UOP_START,
    UOP_DIV,
    UOP_LDMOD,
    UOP_SETEL,
    UOP_ADV,
    UOP_STOP,
    UOP_RESET,
    UOP_EMIT
  } uop_t;

  // sequencer jump conditions
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_DISPATCH,
    JC_LOOP,
    JC_IF_LT,
    JC_WAIT_OUT
  } jc_t;

  // dispatch class of an incoming item
  typedef enum logic [1:0] {
    DSP_TICK,
    DSP_STOP,
    DSP_RESET,
    DSP_NONE
  } disp_t;

  typedef struct packed {
    uop_t            uop;
    jc_t             jc;
    logic [PC_W-1:0] target;
  } ucode_t;

  // control from sequencer to datapath
  typedef struct packed {
    uop_t uop;
    logic fire;
  } ctrl_t;

  // status from datapath to sequencer
  typedef struct packed {
    disp_t disp;
    logic  cnt_last;
    logic  elapsed_lt;
    logic  out_busy;
  } stat_t;

  // program steps
  localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] STEP_START  = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIVFT  = 4'd2;
  localparam logic [PC_W-1:0] STEP_LDMOD  = 4'd3;
  localparam logic [PC_W-1:0] STEP_DIVMOD = 4'd4;
  localparam logic [PC_W-1:0] STEP_SETEL  = 4'd5;
  localparam logic [PC_W-1:0] STEP_ADV    = 4'd6;
  localparam logic [PC_W-1:0] STEP_STOP   = 4'd7;
  localparam logic [PC_W-1:0] STEP_RESET  = 4'd8;
  localparam logic [PC_W-1:0] STEP_EMIT   = 4'd9;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      STEP_IDLE:   w = '{uop: UOP_ACCEPT, jc: JC_DISPATCH, target: STEP_IDLE};
      STEP_START:  w = '{uop: UOP_START,  jc: JC_NEXT,     target: STEP_IDLE};
      STEP_DIVFT:  w = '{uop: UOP_DIV,    jc: JC_LOOP,     target: STEP_IDLE};
      STEP_LDMOD:  w = '{uop: UOP_LDMOD,  jc: JC_IF_LT,    target: STEP_EMIT};
      STEP_DIVMOD: w = '{uop: UOP_DIV,    jc: JC_LOOP,     target: STEP_IDLE};
      STEP_SETEL:  w = '{uop: UOP_SETEL,  jc: JC_NEXT,     target: STEP_IDLE};
      STEP_ADV:    w = '{uop: UOP_ADV,    jc: JC_GOTO,     target: STEP_EMIT};
      STEP_STOP:   w = '{uop: UOP_STOP,   jc: JC_GOTO,     target: STEP_EMIT};
      STEP_RESET:  w = '{uop: UOP_RESET,  jc: JC_GOTO,     target: STEP_EMIT};
      STEP_EMIT:   w = '{uop: UOP_EMIT,   jc: JC_WAIT_OUT, target: STEP_IDLE};
      default:     w = '{uop: UOP_NOP,    jc: JC_GOTO,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* src/fas_cfg.sv */
module fas_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fas_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output fas_pkg::cfg_t                    cfg,
  output logic                             clr_reps
);

  logic [fas_pkg::DUR_W-1:0] dur_r, dur_nxt;
  logic [fas_pkg::SPD_W-1:0] spd_r, spd_nxt;
  logic [fas_pkg::FC_W-1:0]  fc_r, fc_nxt;
  logic [fas_pkg::REP_W-1:0] rep_r, rep_nxt;
  logic                      loop_r, loop_nxt;

  // register writes
  always_comb begin
    dur_nxt  = dur_r;
    spd_nxt  = spd_r;
    fc_nxt   = fc_r;
    rep_nxt  = rep_r;
    loop_nxt = loop_r;
    clr_reps = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        fas_pkg::CFG_DURATION: dur_nxt = cfg_wdata[fas_pkg::DUR_W-1:0];
        fas_pkg::CFG_SPEED:    spd_nxt = cfg_wdata[fas_pkg::SPD_W-1:0];
        fas_pkg::CFG_FRAMES:   fc_nxt  = cfg_wdata[fas_pkg::FC_W-1:0];
        fas_pkg::CFG_REPEAT: begin
          rep_nxt  = cfg_wdata[fas_pkg::REP_W-1:0];
          clr_reps = 1'b1;
        end
        fas_pkg::CFG_LOOP:     loop_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r  <= '0;
      spd_r  <= fas_pkg::SPD_W'(256);
      fc_r   <= fas_pkg::FC_W'(1);
      rep_r  <= '0;
      loop_r <= 1'b0;
    end else begin
      dur_r  <= dur_nxt;
      spd_r  <= spd_nxt;
      fc_r   <= fc_nxt;
      rep_r  <= rep_nxt;
      loop_r <= loop_nxt;
    end
  end

  // zero speed acts as one, frame count clamped to one..max
  always_comb begin
    cfg.duration_ms  = dur_r;
    cfg.speed_eff    = (spd_r == '0) ? fas_pkg::SPD_W'(1) : spd_r;
    if (fc_r == '0) begin
      cfg.frames_eff = fas_pkg::FC_W'(1);
    end else if (fc_r > fas_pkg::FC_W'(fas_pkg::MAX_FRAMES)) begin
      cfg.frames_eff = fas_pkg::FC_W'(fas_pkg::MAX_FRAMES);
    end else begin
      cfg.frames_eff = fc_r;
    end
    cfg.repeat_count = rep_r;
    cfg.loop_enable  = loop_r;
  end

endmodule

/* src/fas_seq.sv */
module fas_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  fas_pkg::stat_t stat,
  output fas_pkg::ctrl_t ctrl,
  output logic           in_stall
);

  logic [fas_pkg::PC_W-1:0] pc_r, pc_nxt;
  fas_pkg::ucode_t          word;
  logic                     idle;

  // control word of the current step
  assign word     = fas_pkg::ucode_rom(pc_r);
  assign idle     = (word.uop == fas_pkg::UOP_ACCEPT);
  assign in_stall = !idle;

  // outputs to the datapath
  always_comb begin
    ctrl.uop  = word.uop;
    ctrl.fire = idle && in_valid;
  end

  // step counter and jumps
  always_comb begin
    pc_nxt = pc_r;
    case (word.jc)
      fas_pkg::JC_NEXT: pc_nxt = pc_r + 1'b1;
      fas_pkg::JC_GOTO: pc_nxt = word.target;
      fas_pkg::JC_DISPATCH: begin
        if (idle && in_valid) begin
          case (stat.disp)
            fas_pkg::DSP_TICK:  pc_nxt = fas_pkg::STEP_START;
            fas_pkg::DSP_STOP:  pc_nxt = fas_pkg::STEP_STOP;
            fas_pkg::DSP_RESET: pc_nxt = fas_pkg::STEP_RESET;
            default:            pc_nxt = fas_pkg::STEP_EMIT;
          endcase
        end
      end
      fas_pkg::JC_LOOP:     pc_nxt = stat.cnt_last ? pc_r + 1'b1 : pc_r;
      fas_pkg::JC_IF_LT:    pc_nxt = stat.elapsed_lt ? word.target : pc_r + 1'b1;
      fas_pkg::JC_WAIT_OUT: pc_nxt = stat.out_busy ? pc_r : word.target;
      default:              pc_nxt = fas_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= fas_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* src/fas_dp.sv */
module fas_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  fas_pkg::ctrl_t    ctrl,
  input  fas_pkg::cfg_t     cfg,
  input  logic              clr_reps,
  input  fas_pkg::in_beat_t in_data,
  input  logic              out_stall,
  output fas_pkg::stat_t    stat,
  output logic              out_valid,
  output fas_pkg::out_beat_t out_data
);

  localparam int DW = fas_pkg::DEN_W;
  localparam int EW = fas_pkg::ELAP_W;

  // animation state
  fas_pkg::mode_t               mode_r, mode_nxt;
  logic [EW-1:0]                elap_r, elap_nxt;
  logic [fas_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [fas_pkg::DISP_W-1:0]   disp_r, disp_nxt;
  logic [fas_pkg::REP_W-1:0]    reps_r, reps_nxt;
  // per-item flags
  logic                         chg_r, chg_nxt;
  logic                         began_r, began_nxt;
  logic                         fin_r, fin_nxt;
  logic                         note_r, note_nxt;
  // divider
  logic [EW-1:0]                num_r, num_nxt;
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [DW-1:0]                den_r, den_nxt;
  logic [fas_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [fas_pkg::DELTA_W-1:0]  delta_r, delta_nxt;
  // result register
  logic                         ov_r, ov_nxt;
  fas_pkg::out_beat_t           od_r, od_nxt;

  logic [EW:0]                  sum;
  logic [fas_pkg::PROD_W-1:0]   prod;
  logic [DW:0]                  rem_sh;
  logic                         q_bit;
  logic [DW:0]                  rem_sub;
  logic [fas_pkg::POS_W-1:0]    pos_inc;
  logic                         out_busy;
  logic                         load_out;

  // shared datapath pieces
  assign sum      = {1'b0, elap_r} + {{(EW + 1 - fas_pkg::DELTA_W){1'b0}}, delta_r};
  assign prod     = fas_pkg::PROD_W'(cfg.speed_eff) * fas_pkg::PROD_W'(cfg.frames_eff);
  assign rem_sh   = {rem_r, num_r[EW-1]};
  assign q_bit    = (rem_sh >= {1'b0, den_r});
  assign rem_sub  = rem_sh - {1'b0, den_r};
  assign pos_inc  = pos_r + 1'b1;
  assign out_busy = ov_r && out_stall;
  assign load_out = (ctrl.uop == fas_pkg::UOP_EMIT) && !out_busy;

  // status to sequencer
  always_comb begin
    if (in_data.func == fas_pkg::FUNC_TICK) begin
      stat.disp = (mode_r == fas_pkg::MODE_INITIAL || mode_r == fas_pkg::MODE_PLAYING) ?
                  fas_pkg::DSP_TICK : fas_pkg::DSP_NONE;
    end else if (in_data.func == fas_pkg::FUNC_STOP) begin
      stat.disp = fas_pkg::DSP_STOP;
    end else if (in_data.func == fas_pkg::FUNC_RESET) begin
      stat.disp = fas_pkg::DSP_RESET;
    end else begin
      stat.disp = fas_pkg::DSP_NONE;
    end
    stat.cnt_last   = (cnt_r == fas_pkg::CNT_W'(1));
    stat.elapsed_lt = (elap_r < {{(EW - DW){1'b0}}, num_r[DW-1:0]});
    stat.out_busy   = out_busy;
  end

  // micro-operation execution
  always_comb begin
    mode_nxt  = mode_r;
    elap_nxt  = elap_r;
    pos_nxt   = pos_r;
    disp_nxt  = disp_r;
    reps_nxt  = reps_r;
    chg_nxt   = chg_r;
    began_nxt = began_r;
    fin_nxt   = fin_r;
    note_nxt  = note_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    delta_nxt = delta_r;
    case (ctrl.uop)
      fas_pkg::UOP_ACCEPT: begin
        if (ctrl.fire) begin
          delta_nxt = in_data.delta_ms;
          chg_nxt   = 1'b0;
          began_nxt = 1'b0;
          fin_nxt   = 1'b0;
          note_nxt  = 1'b0;
        end
      end
      // saturating add, set up frame time division
      fas_pkg::UOP_START: begin
        elap_nxt  = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
        began_nxt = (mode_r != fas_pkg::MODE_PLAYING);
        mode_nxt  = fas_pkg::MODE_PLAYING;
        den_nxt   = DW'(prod);
        num_nxt   = {cfg.duration_ms, 8'b0, {(EW - DW){1'b0}}};
        rem_nxt   = '0;
        cnt_nxt   = fas_pkg::DIV_FT_STEPS;
      end
      // one restoring division step
      fas_pkg::UOP_DIV: begin
        rem_nxt = q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        num_nxt = {num_r[EW-2:0], q_bit};
        cnt_nxt = cnt_r - 1'b1;
      end
      // frame time becomes the divisor, elapsed the dividend
      fas_pkg::UOP_LDMOD: begin
        den_nxt = num_r[DW-1:0];
        num_nxt = elap_r;
        rem_nxt = '0;
        cnt_nxt = fas_pkg::DIV_MOD_STEPS;
      end
      fas_pkg::UOP_SETEL: begin
        elap_nxt = (den_r == '0) ? '0 : {{(EW - DW){1'b0}}, rem_r};
      end
      // frame advance, wrap or completion
      fas_pkg::UOP_ADV: begin
        if (pos_inc >= cfg.frames_eff) begin
          if (!cfg.loop_enable && reps_r >= cfg.repeat_count) begin
            mode_nxt = fas_pkg::MODE_COMPLETED;
            elap_nxt = '0;
            reps_nxt = '0;
            fin_nxt  = 1'b1;
            pos_nxt  = pos_inc;
          end else begin
            if (reps_r < cfg.repeat_count) begin
              reps_nxt = reps_r + 1'b1;
            end
            pos_nxt  = '0;
            disp_nxt = '0;
            chg_nxt  = 1'b1;
          end
        end else begin
          pos_nxt  = pos_inc;
          disp_nxt = pos_inc[fas_pkg::DISP_W-1:0];
          chg_nxt  = 1'b1;
        end
      end
      fas_pkg::UOP_STOP: begin
        mode_nxt = fas_pkg::MODE_STOPPED;
        elap_nxt = '0;
        note_nxt = 1'b1;
      end
      fas_pkg::UOP_RESET: begin
        mode_nxt = fas_pkg::MODE_INITIAL;
        elap_nxt = '0;
        reps_nxt = '0;
        note_nxt = 1'b1;
        pos_nxt  = '0;
        disp_nxt = '0;
        chg_nxt  = 1'b1;
      end
      default: ;
    endcase
    // writing the repeat count clears passes done
    if (clr_reps) begin
      reps_nxt = '0;
    end
  end

  // result register
  always_comb begin
    ov_nxt = out_stall ? ov_r : 1'b0;
    od_nxt = od_r;
    if (load_out) begin
      ov_nxt                = 1'b1;
      od_nxt.play_state     = mode_r;
      od_nxt.shown_frame    = disp_r;
      od_nxt.frame_changed  = chg_r;
      od_nxt.began_playing  = began_r;
      od_nxt.finished       = fin_r;
      od_nxt.control_notice = note_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= fas_pkg::MODE_INITIAL;
      elap_r  <= '0;
      pos_r   <= '0;
      disp_r  <= '0;
      reps_r  <= '0;
      chg_r   <= 1'b0;
      began_r <= 1'b0;
      fin_r   <= 1'b0;
      note_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      elap_r  <= elap_nxt;
      pos_r   <= pos_nxt;
      disp_r  <= disp_nxt;
      reps_r  <= reps_nxt;
      chg_r   <= chg_nxt;
      began_r <= began_nxt;
      fin_r   <= fin_nxt;
      note_r  <= note_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // divider and payload registers
  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    cnt_r   <= cnt_nxt;
    delta_r <= delta_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

/* src/frame_animation_sequencer.sv */
// advancing tick: start, frame time division (28 steps), modulo load, modulo division
// (32 steps), elapsed update, frame advance, result; a tick short of a frame goes from
// modulo load to result, stop and reset take one step first, ignored items go straight
// there; items one at a time through the shared one-bit-per-cycle divider
// reset: synchronous active-low rst_n returns the sequencer to its wait step, clears
// the animation state, empties the result register and restores register defaults
module frame_animation_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fas_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fas_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic [fas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fas_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  fas_pkg::cfg_t  cfg;
  fas_pkg::ctrl_t ctrl;
  fas_pkg::stat_t stat;
  logic           clr_reps;

  // configuration registers
  fas_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .clr_reps  (clr_reps)
  );

  // microprogram sequencer
  fas_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  // datapath with shared divider
  fas_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .clr_reps  (clr_reps),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* src/fas_checker.sv */
module fas_assert (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input fas_pkg::out_beat_t             out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // completion only shows with the completed state
  a_finished_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.finished |->
      out_data.play_state == 2'(fas_pkg::MODE_COMPLETED))
    else $error("finished without completed state");

  // stop and reset notices leave initial or stopped, no tick flags
  a_notice_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.control_notice |->
      (out_data.play_state == 2'(fas_pkg::MODE_STOPPED) ||
       out_data.play_state == 2'(fas_pkg::MODE_INITIAL)) &&
      !out_data.began_playing && !out_data.finished)
    else $error("control notice with tick flags or wrong state");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_animation_sequencer fas_assert u_fas_assert (.*);

/* test/fas_checker.sv */
module fas_checker
  import fas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_beat_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    completions
);

  // register copy
  logic [DUR_W-1:0]  dur_ms;
  logic [SPD_W-1:0]  speed;
  logic [FC_W-1:0]   frame_cnt;
  logic [REP_W-1:0]  repeat_cnt;
  logic              loop_on;

  // animation state
  mode_t             cur_mode;
  logic [ELAP_W-1:0] elapsed_ms;
  logic [POS_W-1:0]  position;
  logic [DISP_W-1:0] disp_frame;
  logic [REP_W-1:0]  passes_done;

  out_beat_t predicted_status_q[$];

  // frame count with range fixes
  function automatic logic [FC_W-1:0] frames_used();
    if (frame_cnt == '0) return FC_W'(1);
    if (frame_cnt > FC_W'(MAX_FRAMES)) return FC_W'(MAX_FRAMES);
    return frame_cnt;
  endfunction

  // time per frame, zero speed counts as one
  function automatic logic [ELAP_W-1:0] frame_time_ms();
    logic [SPD_W-1:0] sp;
    logic [DEN_W-1:0] scaled;
    sp = (speed == '0) ? SPD_W'(1) : speed;
    scaled = {dur_ms, 8'd0} / sp;
    return ELAP_W'(scaled / frames_used());
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] wdata);
    case (idx)
      CFG_DURATION: dur_ms = wdata[DUR_W-1:0];
      CFG_SPEED:    speed = wdata[SPD_W-1:0];
      CFG_FRAMES:   frame_cnt = wdata[FC_W-1:0];
      CFG_REPEAT: begin
        repeat_cnt = wdata[REP_W-1:0];
        passes_done = '0;
      end
      CFG_LOOP:     loop_on = wdata[0];
      default: ;
    endcase
  endtask

  // one item in, one status out
  task automatic step_animation(input in_beat_t beat, output out_beat_t status);
    logic [ELAP_W:0]   sum;
    logic [ELAP_W-1:0] ft;
    logic              changed, began, fin, notice;
    changed = 1'b0;
    began   = 1'b0;
    fin     = 1'b0;
    notice  = 1'b0;
    case (beat.func)
      FUNC_TICK: begin
        if (cur_mode == MODE_INITIAL || cur_mode == MODE_PLAYING) begin
          began = (cur_mode != MODE_PLAYING);
          cur_mode = MODE_PLAYING;
          // saturating accumulate
          sum = {1'b0, elapsed_ms} + (ELAP_W+1)'(beat.delta_ms);
          elapsed_ms = sum[ELAP_W] ? '1 : sum[ELAP_W-1:0];
          ft = frame_time_ms();
          if (elapsed_ms >= ft) begin
            elapsed_ms = (ft == '0) ? '0 : elapsed_ms % ft;
            position = position + POS_W'(1);
            // end of the frames: wrap or complete
            if (position >= frames_used()) begin
              if (!loop_on && passes_done >= repeat_cnt) begin
                cur_mode = MODE_COMPLETED;
                elapsed_ms = '0;
                passes_done = '0;
                fin = 1'b1;
                completions++;
              end else begin
                if (passes_done < repeat_cnt) passes_done = passes_done + REP_W'(1);
                position = '0;
              end
            end
            if (!fin && position < frames_used()) begin
              disp_frame = position[DISP_W-1:0];
              changed = 1'b1;
            end
          end
        end
      end
      FUNC_STOP: begin
        cur_mode = MODE_STOPPED;
        elapsed_ms = '0;
        notice = 1'b1;
      end
      FUNC_RESET: begin
        cur_mode = MODE_INITIAL;
        elapsed_ms = '0;
        passes_done = '0;
        position = '0;
        disp_frame = '0;
        notice = 1'b1;
        changed = 1'b1;
      end
      default: ;
    endcase
    status.play_state     = cur_mode;
    status.shown_frame    = disp_frame;
    status.frame_changed  = changed;
    status.began_playing  = began;
    status.finished       = fin;
    status.control_notice = notice;
  endtask

  task automatic check_status(input out_beat_t got);
    out_beat_t want;
    if (predicted_status_q.size() == 0) begin
      report_mismatch("result beat with nothing pending", 1, 0);
      return;
    end
    want = predicted_status_q.pop_front();
    if (got.play_state != want.play_state)
      report_mismatch("play_state", int'(got.play_state), int'(want.play_state));
    if (got.shown_frame != want.shown_frame)
      report_mismatch("shown_frame", int'(got.shown_frame), int'(want.shown_frame));
    if (got.frame_changed != want.frame_changed)
      report_mismatch("frame_changed", int'(got.frame_changed), int'(want.frame_changed));
    if (got.began_playing != want.began_playing)
      report_mismatch("began_playing", int'(got.began_playing), int'(want.began_playing));
    if (got.finished != want.finished)
      report_mismatch("finished", int'(got.finished), int'(want.finished));
    if (got.control_notice != want.control_notice)
      report_mismatch("control_notice", int'(got.control_notice),
                      int'(want.control_notice));
    results_checked++;
  endtask

  // result beats are checked before new beats are queued
  always @(posedge clk) begin : watch
    out_beat_t status;
    if (!rst_n) begin
      dur_ms = '0;
      speed = SPD_W'(256);
      frame_cnt = FC_W'(1);
      repeat_cnt = '0;
      loop_on = 1'b0;
      cur_mode = MODE_INITIAL;
      elapsed_ms = '0;
      position = '0;
      disp_frame = '0;
      passes_done = '0;
      predicted_status_q.delete();
      fail_count = 0;
      results_checked = 0;
      completions = 0;
    end else begin
      if (out_valid && !out_stall) check_status(out_data);
      if (cfg_we) load_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        step_animation(in_data, status);
        predicted_status_q.insert(predicted_status_q.size(), status);
      end
    end
    pending = predicted_status_q.size();
  end

endmodule

/* test/tb.sv */
module tb;
  import fas_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int RANDOM_BEATS = 410;
  localparam int QUIET_FROM   = 355;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_PHASE   = 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count, pending, results_checked, completions;
  int beats_sent = 0;
  int settings_loaded = 0;
  int ft_est = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  frame_animation_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fas_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .completions     (completions)
  );

  // watchdog
  initial begin
    #5_000_000;
    $display("[frame_animation_sequencer] ERROR");
    $finish;
  end

  // result side back-pressure: random bursts and one long hold
  initial begin : rx_stall
    int n;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // rough frame time, only to aim tick lengths
  function automatic int est_frame_time(input int dur, input int spd, input int fc);
    int n;
    n = (fc == 0) ? 1 : (fc > MAX_FRAMES) ? MAX_FRAMES : fc;
    return (dur * 256 / ((spd == 0) ? 1 : spd)) / n;
  endfunction

  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [DELTA_W-1:0] d);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: f, delta_ms: d};
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // drop valid and wait for every pending status beat
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] wdata);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // all five registers, junk in the unused upper bits, plus one unmapped index
  task automatic load_setting(input int dur, input int spd, input int fc,
                              input int rep, input bit lp);
    write_reg(CFG_DURATION, CFG_DATA_W'(dur));
    write_reg(CFG_SPEED, {4'($urandom), 16'(spd)});
    write_reg(CFG_FRAMES, {13'($urandom), 7'(fc)});
    write_reg(CFG_REPEAT, {12'($urandom), 8'(rep)});
    write_reg(CFG_LOOP, {19'($urandom), lp});
    write_reg(CFG_IDX_W'(5 + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
    close_writes();
    ft_est = est_frame_time(dur, spd, fc);
    settings_loaded++;
  endtask

  initial begin : stimulus
    int phase, n, k, r, random_beats;
    int dur, spd, fc, rep;
    bit lp;
    logic [FUNC_W-1:0]  f;
    logic [DELTA_W-1:0] d;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // defaults: zero duration, single frame, so the first tick completes
    send_beat(FUNC_NONE, 16'h0000);
    send_beat(FUNC_TICK, 16'h0000);
    send_beat(FUNC_TICK, 16'hFFFF);
    send_beat(FUNC_STOP, 16'h1234);
    send_beat(FUNC_TICK, 16'h0040);
    send_beat(FUNC_NONE, 16'hFFFF);
    send_beat(FUNC_RESET, 16'h0000);
    settle();

    // four frames of 250 ms, one extra pass, then completion
    load_setting(1000, 256, 4, 1, 1'b0);
    send_beat(FUNC_TICK, 16'd100);
    send_beat(FUNC_TICK, 16'd200);
    send_beat(FUNC_TICK, 16'hFFFF);
    repeat (6) send_beat(FUNC_TICK, 16'd250);
    settle();

    // zero speed and zero frame count: frame time far beyond any tick
    load_setting(1048575, 0, 0, 255, 1'b1);
    send_beat(FUNC_RESET, 16'hFFFF);
    send_beat(FUNC_TICK, 16'hFFFF);
    send_beat(FUNC_TICK, 16'h0000);
    settle();

    // oversized frame count, fastest speed: one frame per long tick
    load_setting(1048575, 65535, 127, 0, 1'b0);
    send_beat(FUNC_RESET, 16'h0000);
    repeat (3) send_beat(FUNC_TICK, 16'hFFFF);
    settle();

    // frame count lowered below the current position
    write_reg(CFG_FRAMES, CFG_DATA_W'(2));
    close_writes();
    ft_est = est_frame_time(1048575, 65535, 2);
    send_beat(FUNC_TICK, 16'hFFFF);

    // random phases
    random_beats = 0;
    phase = 0;
    while (random_beats < RANDOM_BEATS) begin
      settle();
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: load_setting(0, 1, 64, 255, 1'b0);
          1: load_setting(1048575, 65535, 1, 0, 1'b1);
          2: load_setting($urandom_range(0, 1048575), 0, 127,
                          $urandom_range(0, 255), 1'($urandom_range(0, 1)));
          default: load_setting(500, 65535, 0, 3, 1'b0);
        endcase
      end else begin
        dur = $urandom_range(0, 3000);
        spd = $urandom_range(0, 1) ? 256 : $urandom_range(1, 1024);
        fc  = $urandom_range(1, 5);
        rep = $urandom_range(0, 2);
        lp  = ($urandom_range(0, 3) == 0);
        load_setting(dur, spd, fc, rep, lp);
      end
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      if ($urandom_range(0, 1) == 0) begin
        send_beat(FUNC_RESET, 16'($urandom));
        random_beats++;
      end
      n = $urandom_range(10, 40);
      for (k = 0; k < n && random_beats < RANDOM_BEATS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 84) f = FUNC_TICK;
        else if (r < 91) f = FUNC_RESET;
        else if (r < 96) f = FUNC_STOP;
        else f = FUNC_NONE;
        // tick lengths mostly near the frame time
        r = $urandom_range(0, 9);
        if (r < 7) begin
          if (2 * ft_est + 1 > 65535) d = 16'($urandom);
          else d = 16'($urandom_range(0, 2 * ft_est + 1));
        end else if (r < 9) begin
          d = 16'($urandom);
        end else begin
          d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        send_beat(f, d);
        if (f != FUNC_NONE) random_beats++;
        if (random_beats >= QUIET_FROM) quiet = 1'b1;
      end
      phase++;
    end

    // drain
    settle();
    repeat (80) @(posedge clk);
    $display("run covered %0d input beats under %0d register settings, %0d status beats checked",
             beats_sent, settings_loaded, results_checked);
    $display("animations run to completion: %0d", completions);
    if (fail_count == 0) begin
      $display("[frame_animation_sequencer] OK");
    end else begin
      $display("[frame_animation_sequencer] ERROR");
    end
    $finish;
  end

endmodule

/* frame_animation_sequencer.f */
src/fas_pkg.sv
src/fas_cfg.sv
src/fas_seq.sv
src/fas_dp.sv
src/frame_animation_sequencer.sv
src/fas_checker.sv
test/fas_checker.sv
test/tb.sv
